@@ rtl/core/srsg_pkg.sv @@
// Shared types, constants and the sine table function of the sine reference generator.
package srsg_pkg;

  localparam int MAX_POSTURES_DEF = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int AMP_W = 26;
  localparam int OMEGA_W = 24;
  localparam int OUT_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AMP_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POSTURE_COUNT = 3'd6;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [31:0] HOLD_RESET = 32'd2000;

  localparam longint C1 = 64'sd1686629713;
  localparam longint C3 = 64'sd693598669;
  localparam longint C5 = 64'sd85569306;
  localparam longint C7 = 64'sd5026995;
  localparam longint C9 = 64'sd172272;

  // Multiplier operation chosen by the controller.
  typedef enum logic [2:0] {
    MUL_POS,
    MUL_VELA,
    MUL_VELB,
    MUL_ACCA,
    MUL_ACCB
  } mul_op_t;

  typedef struct packed {
    logic    start;
    logic    load;
    logic    tick;
    logic    hold_out;
    logic    mul_en;
    mul_op_t mul_op;
    logic [1:0] axis;
    logic    sched_clr;
    logic    sched_en;
    logic    out_load;
  } srsg_cmd_t;

  typedef struct packed {
    logic holding;
    logic sched_done;
  } srsg_sts_t;

  // Quarter-wave sine, Q30 in and out, evaluated at elaboration for a table.
  function automatic longint quarter_sin(input longint x);
    longint x2, t;
    begin
      x2 = (x * x) >>> 30;
      t = C9;
      t = C7 - ((x2 * t) >>> 30);
      t = C5 - ((x2 * t) >>> 30);
      t = C3 - ((x2 * t) >>> 30);
      t = C1 - ((x2 * t) >>> 30);
      if (t < 0) t = 0;
      t = (x * t) >>> 30;
      quarter_sin = (t > (64'sd1 << 30)) ? (64'sd1 << 30) : t;
    end
  endfunction

  function automatic logic signed [31:0] table_sin(input logic [31:0] pq);
    longint f, s;
    begin
      f = longint'({34'd0, pq[29:0]});
      s = pq[30] ? quarter_sin((64'sd1 << 30) - f) : quarter_sin(f);
      if (pq[31]) s = -s;
      table_sin = s[31:0];
    end
  endfunction

  // Round to nearest, ties up, by 2^s.
  function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
    begin
      rnd = (v + (80'sd1 <<< (s - 1))) >>> s;
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [79:0] v);
    begin
      if (v > 80'sh7FFFFFFFFFFF) sat48 = {1'b0, {(OUT_W-1){1'b1}}};
      else if (v < -80'sh800000000000) sat48 = {1'b1, {(OUT_W-1){1'b0}}};
      else sat48 = v[OUT_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/srsg_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module srsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/srsg_ctrl.sv @@
// Controller state machine that sequences one beat through the datapath.
module srsg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  logic                 out_busy,
  input  srsg_pkg::srsg_sts_t  sts,
  output srsg_pkg::srsg_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_MUL, S_SCHED, S_OUT
  } state_t;

  state_t state;
  logic [2:0] sub;
  logic [1:0] axis;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.start = in_ready && in_valid;
    cmd.load = cmd.start && (in_op == srsg_pkg::OP_LOAD);
    cmd.tick = cmd.start && (in_op == srsg_pkg::OP_TICK);
    cmd.axis = axis;
    cmd.mul_op = srsg_pkg::MUL_POS;
    unique case (state)
      S_MUL: begin
        cmd.mul_en = 1'b1;
        unique case (sub)
          3'd0: cmd.mul_op = srsg_pkg::MUL_POS;
          3'd1: cmd.mul_op = srsg_pkg::MUL_VELA;
          3'd2: cmd.mul_op = srsg_pkg::MUL_VELB;
          3'd3: cmd.mul_op = srsg_pkg::MUL_ACCA;
          default: cmd.mul_op = srsg_pkg::MUL_ACCB;
        endcase
        cmd.sched_clr = (axis == 2'd0) && (sub == 3'd0);
      end
      S_SCHED: cmd.sched_en = 1'b1;
      S_OUT: begin
        cmd.out_load = !out_busy;
        cmd.hold_out = sts.holding;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sub <= '0;
      axis <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.tick) state <= S_TICK;
        S_TICK: begin
          sub <= '0;
          axis <= '0;
          state <= sts.holding ? S_OUT : S_MUL;
        end
        S_MUL: begin
          if (sub == 3'd4) begin
            sub <= '0;
            axis <= axis + 2'd1;
            if (axis == 2'd2) state <= S_SCHED;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_SCHED: if (sts.sched_done) state <= S_OUT;
        S_OUT: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.mul_en |-> !sts.holding)
    else $error("multiplier run while holding");
  assert property (@(posedge clk) disable iff (rst) cmd.tick |=> !in_ready)
    else $error("accepted tick beat did not leave idle");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> in_ready)
    else $error("result load did not return to idle");

endmodule

@@ rtl/core/srsg_dp.sv @@
// Datapath: counters, phase, sine table, shared multiplier and schedule search.
module srsg_dp #(
  parameter int MAX_POSTURES = srsg_pkg::MAX_POSTURES_DEF,
  parameter int SINE_TABLE_BITS = srsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srsg_pkg::srsg_cmd_t  cmd,
  output srsg_pkg::srsg_sts_t  sts,
  input  logic [3:0]           entry_index,
  input  logic [31:0]          entry_time,
  input  logic                 cfg_we,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [srsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                 out_taken,
  output logic                 out_busy,
  output logic [9*srsg_pkg::OUT_W-1:0] res_vec,
  output logic [3:0]           res_index,
  output logic                 res_initial,
  output logic                 res_holding
);

  localparam int IDX_W = $clog2(MAX_POSTURES);
  localparam int CNT_W = $clog2(MAX_POSTURES + 1);
  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QDEPTH = 1 << QBITS;
  localparam int OW = srsg_pkg::OUT_W;
  localparam logic signed [31:0] QEND = srsg_pkg::table_sin(32'h4000_0000);

  logic signed [srsg_pkg::AMP_W-1:0] amp [3];
  logic [srsg_pkg::OMEGA_W-1:0] omega;
  logic [31:0] phase_step, hold_ticks, elapsed, phase_acc;
  logic [4:0] posture_count;

  // The first quadrant of the sine; the other three follow by symmetry.
  logic signed [31:0] qtab [QDEPTH];
  always_comb
    for (int k = 0; k < QDEPTH; k++)
      qtab[k] = srsg_pkg::table_sin(32'(k) << (32 - SINE_TABLE_BITS));

  function automatic logic signed [31:0] lookup(input logic [31:0] ph);
    logic [QBITS-1:0] q;
    logic signed [31:0] m;
    q = ph[29 -: QBITS];
    if (!ph[30]) m = qtab[q];
    else if (q == '0) m = QEND;
    else m = qtab[QBITS'(-q)];
    return ph[31] ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) amp[k] <= '0;
      omega <= '0;
      phase_step <= '0;
      hold_ticks <= srsg_pkg::HOLD_RESET;
      posture_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srsg_pkg::REG_AMP_X: amp[0] <= cfg_data[srsg_pkg::AMP_W-1:0];
        srsg_pkg::REG_AMP_Y: amp[1] <= cfg_data[srsg_pkg::AMP_W-1:0];
        srsg_pkg::REG_AMP_Z: amp[2] <= cfg_data[srsg_pkg::AMP_W-1:0];
        srsg_pkg::REG_OMEGA: omega <= cfg_data[srsg_pkg::OMEGA_W-1:0];
        srsg_pkg::REG_PHASE_STEP: phase_step <= cfg_data;
        srsg_pkg::REG_HOLD_TICKS: hold_ticks <= cfg_data;
        srsg_pkg::REG_POSTURE_COUNT: posture_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic holding;
  logic signed [31:0] s_val, c_val;
  logic [31:0] cos_ph;
  assign cos_ph = phase_acc + 32'h4000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      phase_acc <= '0;
      holding <= 1'b1;
    end else if (cmd.tick) begin
      if (elapsed != '1) begin
        elapsed <= elapsed + 32'd1;
        holding <= (elapsed + 32'd1) < hold_ticks;
      end else begin
        holding <= elapsed < hold_ticks;
      end
    end else if (cmd.sched_clr) begin
      phase_acc <= phase_acc + phase_step;
    end
  end

  always_ff @(posedge clk)
    if (cmd.sched_clr || cmd.tick) begin
      s_val <= lookup(phase_acc);
      c_val <= lookup(cos_ph);
    end

  // Shared multiplier: one 32x34 product per cycle, registered.
  logic signed [OW-1:0] pos_r [3];
  logic signed [OW-1:0] vel_r [3];
  logic signed [OW-1:0] acc_r [3];
  logic signed [OW:0] tmp;
  logic signed [31:0] ma;
  logic signed [33:0] mb;
  logic signed [79:0] prod, rnd30, rnd16;
  logic signed [srsg_pkg::AMP_W-1:0] cur_amp;
  assign cur_amp = amp[cmd.axis];

  always_comb begin
    ma = 32'(cur_amp);
    mb = 34'(s_val);
    unique case (cmd.mul_op)
      srsg_pkg::MUL_POS: begin ma = 32'(cur_amp); mb = 34'(s_val); end
      srsg_pkg::MUL_VELA: begin ma = 32'(cur_amp); mb = 34'(c_val); end
      srsg_pkg::MUL_VELB: begin ma = $signed({8'd0, omega}); mb = 34'(tmp); end
      srsg_pkg::MUL_ACCA: begin ma = $signed({8'd0, omega}); mb = 34'(tmp); end
      default: begin ma = $signed({8'd0, omega}); mb = 34'(tmp); end
    endcase
    prod = 80'(ma) * 80'(mb);
    rnd30 = srsg_pkg::rnd(prod, 30);
    rnd16 = srsg_pkg::rnd(prod, 16);
  end

  always_ff @(posedge clk)
    if (cmd.mul_en) begin
      unique case (cmd.mul_op)
        srsg_pkg::MUL_POS: begin
          pos_r[cmd.axis] <= srsg_pkg::sat48(rnd30);
          tmp <= (OW+1)'(rnd30);
        end
        srsg_pkg::MUL_VELA: tmp <= (OW+1)'(rnd30);
        srsg_pkg::MUL_VELB: begin
          vel_r[cmd.axis] <= srsg_pkg::sat48(rnd16);
          tmp <= (OW+1)'(pos_r[cmd.axis]);
        end
        srsg_pkg::MUL_ACCA: tmp <= (OW+1)'(rnd16);
        default: acc_r[cmd.axis] <= srsg_pkg::sat48(-rnd16);
      endcase
    end

  // Schedule search, one entry read per cycle from the time memory.
  logic [IDX_W-1:0] raddr, waddr;
  logic [31:0] rdata, prev_t;
  logic [CNT_W-1:0] n_eff, scan;
  logic [IDX_W-1:0] sel;
  logic found, have_prev, sched_done;
  assign waddr = IDX_W'(entry_index);
  assign n_eff = (32'(posture_count) > 32'(MAX_POSTURES)) ? CNT_W'(MAX_POSTURES)
                                                          : CNT_W'(posture_count);
  assign raddr = scan[IDX_W-1:0];

  srsg_ram #(.WIDTH(32), .DEPTH(MAX_POSTURES)) u_times (
    .clk(clk), .we(cmd.load && (32'(entry_index) < 32'(MAX_POSTURES))),
    .waddr(waddr), .wdata(entry_time), .raddr(raddr), .rdata(rdata)
  );

  logic [CNT_W-1:0] rd_i;
  always_ff @(posedge clk) begin
    if (cmd.sched_clr) begin
      scan <= '0;
      rd_i <= '0;
      have_prev <= 1'b0;
      found <= 1'b0;
      sel <= IDX_W'(n_eff - CNT_W'(1));
      sched_done <= 1'b0;
    end else if (cmd.sched_en && !sched_done) begin
      if (scan < n_eff - CNT_W'(1) || scan == '0) scan <= scan + CNT_W'(1);
      rd_i <= scan;
      if (have_prev && !found && elapsed > prev_t && elapsed <= rdata) begin
        found <= 1'b1;
        sel <= IDX_W'(rd_i - CNT_W'(1));
      end
      prev_t <= rdata;
      have_prev <= (scan != '0);
      if (n_eff < CNT_W'(2) || (have_prev && rd_i == n_eff - CNT_W'(1)))
        sched_done <= 1'b1;
    end
  end

  always_comb begin
    sts.holding = holding;
    sts.sched_done = sched_done;
  end

  always_ff @(posedge clk) begin
    if (rst) out_busy <= 1'b0;
    else if (cmd.out_load) out_busy <= 1'b1;
    else if (out_taken) out_busy <= 1'b0;
  end

  always_ff @(posedge clk)
    if (cmd.out_load) begin
      res_holding <= cmd.hold_out;
      res_initial <= cmd.hold_out || (n_eff < CNT_W'(2));
      res_index <= (cmd.hold_out || n_eff < CNT_W'(2)) ? 4'd0 : 4'(sel);
      for (int k = 0; k < 3; k++) begin
        res_vec[k*OW +: OW] <= cmd.hold_out ? '0 : pos_r[k];
        res_vec[(3+k)*OW +: OW] <= cmd.hold_out ? '0 : vel_r[k];
        res_vec[(6+k)*OW +: OW] <= cmd.hold_out ? '0 : acc_r[k];
      end
    end

endmodule

@@ rtl/core/sine_reference_and_schedule_generator_core.sv @@
// Top level of the sine reference and posture schedule generator.
// One beat at a time: a load beat is taken straight from idle; a tick beat in hold passes
// through the tick and output states, and a moving tick also makes fifteen passes through
// the shared multiplier and a schedule scan of one time entry per cycle from the time
// memory. A result that is still waiting at the output holds the next tick in its output
// state until that result is taken.
// tdata of s_axis: entry_index, entry_time; tuser: opcode. tdata of m_axis: nine 48-bit
// offsets then posture_index; tuser: use_initial, holding.
module sine_reference_and_schedule_generator_core #(
  parameter int MAX_POSTURES = srsg_pkg::MAX_POSTURES_DEF,
  parameter int SINE_TABLE_BITS = srsg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // entry_index, entry_time, zero fill
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [439:0] m_axis_tdata,  // pos_x..z, vel_x..z, acc_x..z, posture_index, fill
  output logic [1:0]   m_axis_tuser,  // use_initial, holding
  input  logic         cfg_we,
  input  logic [srsg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [srsg_pkg::CFG_DATA_W-1:0] cfg_data
);

  srsg_pkg::srsg_cmd_t cmd;
  srsg_pkg::srsg_sts_t sts;
  logic out_busy;
  logic [9*srsg_pkg::OUT_W-1:0] res_vec;
  logic [3:0] res_index;
  logic res_initial, res_holding;

  srsg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_op(s_axis_tuser),
    .in_ready(s_axis_tready), .out_busy(out_busy), .sts(sts), .cmd(cmd)
  );

  srsg_dp #(.MAX_POSTURES(MAX_POSTURES), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .entry_index(s_axis_tdata[3:0]), .entry_time(s_axis_tdata[35:4]),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .out_taken(m_axis_tready), .out_busy(out_busy), .res_vec(res_vec),
    .res_index(res_index), .res_initial(res_initial), .res_holding(res_holding)
  );

  assign m_axis_tvalid = out_busy;
  assign m_axis_tdata = {4'd0, res_index, res_vec};
  assign m_axis_tuser = {res_holding, res_initial};

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the sine reference and posture schedule generator core.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] tm;
  } beat_t;

  typedef struct packed {
    logic [1:0]   user;
    logic [439:0] data;
  } ref_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [439:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [srsg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [srsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sine_reference_and_schedule_generator_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state.
  longint      amp_q [3];
  logic [23:0] omega_q;
  logic [31:0] step_q, hold_q, elapsed_q, phase_q;
  logic [4:0]  count_q;
  logic [31:0] times_q [16];

  beat_t     pending [$];
  ref_beat_t expected_refs [$];
  beat_t     cur;
  int        issued = 0, accepted = 0, mismatches = 0;
  int        snd_idle = 0, rcv_idle = 0;
  string     names [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                           "acc_x", "acc_y", "acc_z"};

  function automatic longint qsin(input longint x);
    longint x2, t;
    x2 = (x * x) >> 30;
    t = 172272;
    t = 5026995 - ((x2 * t) >> 30);
    t = 85569306 - ((x2 * t) >> 30);
    t = 693598669 - ((x2 * t) >> 30);
    t = 1686629713 - ((x2 * t) >> 30);
    if (t < 0) t = 0;
    t = (x * t) >> 30;
    return (t > (64'sd1 << 30)) ? (64'sd1 << 30) : t;
  endfunction

  function automatic longint tsin(input logic [31:0] ph);
    longint f, s;
    f = longint'({ph[29:22], 22'd0});
    s = ph[30] ? qsin((64'sd1 << 30) - f) : qsin(f);
    return ph[31] ? -s : s;
  endfunction

  function automatic longint rnd(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [47:0] sat(input longint v);
    if (v > 64'sh7FFFFFFFFFFF) return 48'h7FFFFFFFFFFF;
    if (v < -64'sh800000000000) return 48'h800000000000;
    return v[47:0];
  endfunction

  task automatic generator_step(input beat_t b);
    ref_beat_t r;
    longint s, c, om, pos, vel, acc;
    int n, sel;
    logic found;
    if (b.op == srsg_pkg::OP_LOAD) begin
      times_q[b.idx] = b.tm;
      return;
    end
    if (elapsed_q != 32'hFFFFFFFF) elapsed_q = elapsed_q + 1;
    r = '0;
    if (elapsed_q < hold_q) begin
      r.user = 2'b11;
    end else begin
      s = tsin(phase_q);
      c = tsin(phase_q + 32'h40000000);
      om = longint'({40'd0, omega_q});
      for (int a = 0; a < 3; a++) begin
        pos = rnd(amp_q[a] * s, 30);
        vel = rnd(om * rnd(amp_q[a] * c, 30), 16);
        acc = -rnd(om * rnd(om * pos, 16), 16);
        r.data[48*a +: 48] = sat(pos);
        r.data[48*(3+a) +: 48] = sat(vel);
        r.data[48*(6+a) +: 48] = sat(acc);
      end
      phase_q = phase_q + step_q;
      n = (count_q > 16) ? 16 : count_q;
      if (n >= 2) begin
        sel = n - 1;
        found = 1'b0;
        for (int i = 0; i + 1 < n; i++) begin
          if (!found && elapsed_q > times_q[i] && elapsed_q <= times_q[i+1]) begin
            sel = i;
            found = 1'b1;
          end
        end
        r.data[435:432] = sel[3:0];
        r.user = 2'b00;
      end else begin
        r.user = 2'b01;
      end
    end
    expected_refs.push_back(r);
  endtask

  task automatic set_reg(input logic [srsg_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      srsg_pkg::REG_AMP_X: amp_q[0] = {{38{data[25]}}, data[25:0]};
      srsg_pkg::REG_AMP_Y: amp_q[1] = {{38{data[25]}}, data[25:0]};
      srsg_pkg::REG_AMP_Z: amp_q[2] = {{38{data[25]}}, data[25:0]};
      srsg_pkg::REG_OMEGA: omega_q = data[23:0];
      srsg_pkg::REG_PHASE_STEP: step_q = data;
      srsg_pkg::REG_HOLD_TICKS: hold_q = data;
      srsg_pkg::REG_POSTURE_COUNT: count_q = data[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_beat(input logic op, input logic [3:0] idx, input logic [31:0] tm);
    beat_t b;
    b.op = op;
    b.idx = idx;
    b.tm = tm;
    pending.push_back(b);
    issued++;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || accepted != issued) @(posedge clk);
    while (expected_refs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_amp();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 32'h01000000;
    if (k == 1) return 32'hFF000000;
    return $urandom_range(0, 33554432) - 32'd16777216;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        generator_step(cur);
        accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
          cur = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'd0, cur.tm, cur.idx};
          s_axis_tuser <= cur.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ref_beat_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_refs.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          e = expected_refs.pop_front();
          for (int f = 0; f < 9; f++)
            if (m_axis_tdata[48*f +: 48] !== e.data[48*f +: 48]) begin
              $error("%s: expected %h, got %h", names[f], e.data[48*f +: 48],
                     m_axis_tdata[48*f +: 48]);
              mismatches++;
            end
          if (m_axis_tdata[435:432] !== e.data[435:432]) begin
            $error("posture_index: expected %0d, got %0d", e.data[435:432],
                   m_axis_tdata[435:432]);
            mismatches++;
          end
          if (m_axis_tuser[0] !== e.user[0]) begin
            $error("use_initial: expected %b, got %b", e.user[0], m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tuser[1] !== e.user[1]) begin
            $error("holding: expected %b, got %b", e.user[1], m_axis_tuser[1]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    amp_q = '{0, 0, 0};
    omega_q = '0;
    step_q = '0;
    hold_q = srsg_pkg::HOLD_RESET;
    count_q = '0;
    elapsed_q = '0;
    phase_q = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_reg(srsg_pkg::REG_AMP_X, 32'h01000000);
    set_reg(srsg_pkg::REG_AMP_Y, 32'hFF000000);
    set_reg(srsg_pkg::REG_AMP_Z, 32'h00000000);
    set_reg(srsg_pkg::REG_OMEGA, 32'h00FFFFFF);
    set_reg(srsg_pkg::REG_PHASE_STEP, 32'h40000000);
    set_reg(srsg_pkg::REG_HOLD_TICKS, 32'd3);
    set_reg(srsg_pkg::REG_POSTURE_COUNT, 32'd16);
    set_reg(3'd7, $urandom);
    // Every schedule time is written before any scan can read it.
    for (int i = 0; i < 16; i++)
      push_beat(srsg_pkg::OP_LOAD, i[3:0], (i == 15) ? 32'hFFFFFFFF : 32'(i * 2));
    for (int i = 0; i < 9; i++) push_beat(srsg_pkg::OP_TICK, 4'd0, 32'd0);
    wait_idle();
    for (int p = 0; p < 10; p++) begin
      snd_idle <= (p % 3 == 0) ? 17 : (p % 3 == 1) ? 83 : 0;
      rcv_idle <= (p % 3 == 0) ? 83 : (p % 3 == 1) ? 17 : 0;
      set_reg(srsg_pkg::REG_AMP_X, pick_amp());
      set_reg(srsg_pkg::REG_AMP_Y, pick_amp());
      set_reg(srsg_pkg::REG_AMP_Z, pick_amp());
      set_reg(srsg_pkg::REG_OMEGA, (p == 2) ? 32'd0 : (p == 5) ? 32'h00FFFFFF : $urandom);
      set_reg(srsg_pkg::REG_PHASE_STEP, (p == 3) ? 32'd0 : (p == 4) ? 32'hFFFFFFFF :
              $urandom);
      set_reg(srsg_pkg::REG_HOLD_TICKS, (p == 1) ? 32'hFFFFFFFF : (p == 6) ? 32'd0 :
              $urandom_range(0, 900));
      set_reg(srsg_pkg::REG_POSTURE_COUNT, (p == 7) ? 32'd31 : (p == 8) ? 32'd1 :
              (p == 9) ? 32'd0 : $urandom_range(0, 31));
      for (int k = 0; k < 70; k++) begin
        if ($urandom_range(0, 4) == 0)
          push_beat(srsg_pkg::OP_LOAD, 4'($urandom_range(0, 15)),
                    $urandom_range(0, 1) ? $urandom_range(0, 1200) : $urandom);
        else
          push_beat(srsg_pkg::OP_TICK, 4'($urandom), $urandom);
      end
      wait_idle();
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
